[rtl/core/ptt_pkg.sv]
// ----------------------------------------------------------------------------
// ptt_pkg: shared types and constants for the point-in-tetrahedron test
// Coordinate and determinant widths, the result codes and the coordinate
// unpacking helper used by every determinant pipeline.
// ----------------------------------------------------------------------------
package ptt_pkg;

   localparam int COORD_W   = 16;             // bits per signed coordinate
   localparam int FIELD_W   = 48;             // bits per packed point field
   localparam int REF_W     = 55;             // reported determinant width
   localparam int DIFF_W    = COORD_W + 1;    // edge vector component
   localparam int PROD_W    = 2 * DIFF_W;     // product of two components
   localparam int MINOR_W   = PROD_W + 1;     // 2x2 minor
   localparam int TRIP_W    = MINOR_W + DIFF_W; // component times minor
   localparam int DET_W     = 3 * COORD_W + 7; // full determinant, exact
   localparam int DET_STAGES = 5;             // register stages in a det pipe
   localparam int RSP_DATA_W = 64;            // 2 + 55 bits, padded to bytes

   typedef enum logic [1:0] {
      POS_INSIDE     = 2'd0,
      POS_OUTSIDE    = 2'd1,
      POS_DEGENERATE = 2'd2
   } pos_code_type;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DET_W-1:0]   det_type;

   // reference determinant plus the four with the query swapped in
   typedef struct packed {
      det_type d0;
      det_type d1;
      det_type d2;
      det_type d3;
      det_type d4;
   } det_set_type;

   // Pick coordinate idx out of a packed point; bits above the field read zero.
   function automatic coord_type get_coord(input logic [FIELD_W-1:0] f,
                                           input int idx);
      logic [3*COORD_W-1:0] pad;
      pad = (3*COORD_W)'(f);
      return coord_type'(pad[idx*COORD_W +: COORD_W]);
   endfunction

   // Wrap or sign-extend a full determinant to the reported width.
   function automatic logic [REF_W-1:0] ref_bits(input det_type d);
      logic signed [63:0] wide;
      wide = 64'(d);
      return wide[REF_W-1:0];
   endfunction

endpackage

[rtl/core/ptt_det_pipe.sv]
// ----------------------------------------------------------------------------
// ptt_det_pipe: five-stage pipelined 4x4 homogeneous determinant
// Rows (p,1),(q,1),(r,1),(s,1); the result is -det3(q-p, r-p, s-p).
// Stages: edge vectors, minor products, minors, cofactor products, sum.
// ----------------------------------------------------------------------------
module ptt_det_pipe
   import ptt_pkg::*;
(
   input  logic                clock,
   input  logic                adv,
   input  logic [FIELD_W-1:0]  pnt_p,
   input  logic [FIELD_W-1:0]  pnt_q,
   input  logic [FIELD_W-1:0]  pnt_r,
   input  logic [FIELD_W-1:0]  pnt_s,
   output det_type             det
);

   logic signed [DIFF_W-1:0]  u_ff [3], v_ff [3], w_ff [3];
   logic signed [DIFF_W-1:0]  u_in [3], v_in [3], w_in [3];
   logic signed [DIFF_W-1:0]  u2_ff [3], u3_ff [3];
   logic signed [PROD_W-1:0]  pr_ff [6];
   logic signed [PROD_W-1:0]  pr_in [6];
   logic signed [MINOR_W-1:0] mn_ff [3];
   logic signed [MINOR_W-1:0] mn_in [3];
   logic signed [TRIP_W-1:0]  tp_ff [3];
   logic signed [TRIP_W-1:0]  tp_in [3];
   det_type                   det_ff, det_in;
   det_type                   sum;

   // stage 1: edge vectors from p
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         u_in[i] = DIFF_W'(get_coord(pnt_q, i)) - DIFF_W'(get_coord(pnt_p, i));
         v_in[i] = DIFF_W'(get_coord(pnt_r, i)) - DIFF_W'(get_coord(pnt_p, i));
         w_in[i] = DIFF_W'(get_coord(pnt_s, i)) - DIFF_W'(get_coord(pnt_p, i));
      end
   end

   // stage 2: the six products behind the 2x2 minors of v, w
   always_comb begin
      pr_in[0] = PROD_W'(v_ff[1]) * PROD_W'(w_ff[2]);
      pr_in[1] = PROD_W'(v_ff[2]) * PROD_W'(w_ff[1]);
      pr_in[2] = PROD_W'(v_ff[0]) * PROD_W'(w_ff[2]);
      pr_in[3] = PROD_W'(v_ff[2]) * PROD_W'(w_ff[0]);
      pr_in[4] = PROD_W'(v_ff[0]) * PROD_W'(w_ff[1]);
      pr_in[5] = PROD_W'(v_ff[1]) * PROD_W'(w_ff[0]);
   end

   // stage 3: minors
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mn_in[i] = MINOR_W'(pr_ff[2*i]) - MINOR_W'(pr_ff[2*i+1]);
      end
   end

   // stage 4: cofactor products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tp_in[i] = TRIP_W'(u3_ff[i]) * TRIP_W'(mn_ff[i]);
      end
   end

   // stage 5: expand along u and flip sign for the homogeneous column
   always_comb begin
      sum    = DET_W'(tp_ff[0]) - DET_W'(tp_ff[1]) + DET_W'(tp_ff[2]);
      det_in = -sum;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         u_ff   <= u_in;
         v_ff   <= v_in;
         w_ff   <= w_in;
         pr_ff  <= pr_in;
         u2_ff  <= u_ff;
         mn_ff  <= mn_in;
         u3_ff  <= u2_ff;
         tp_ff  <= tp_in;
         det_ff <= det_in;
      end
   end

   assign det = det_ff;

endmodule

[rtl/core/ptt_out_stage.sv]
// ----------------------------------------------------------------------------
// ptt_out_stage: classification and registered output with a skid slot
// Turns the five determinants into a position code and holds the result
// beat; the skid slot keeps the pipeline advance off the response ready.
// ----------------------------------------------------------------------------
module ptt_out_stage
   import ptt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  det_set_type           dets,
   output logic                  in_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // [1:0] position_code, [56:2] reference_det
);

   logic [RSP_DATA_W-1:0] beat_in;
   logic [RSP_DATA_W-1:0] out_data_ff, skid_data_ff;
   logic                  out_valid_ff, skid_valid_ff;
   logic                  push;
   logic                  all_match;
   logic                  same [4];
   det_type               di [4];
   pos_code_type          code;
   logic [REF_W-1:0]      ref_det;

   always_comb begin
      di[0] = dets.d1;
      di[1] = dets.d2;
      di[2] = dets.d3;
      di[3] = dets.d4;
      all_match = 1'b1;
      for (int i = 0; i < 4; i++) begin
         // strict sign match: a zero means the point sits on a face
         same[i]   = (di[i] != '0) && (di[i][DET_W-1] == dets.d0[DET_W-1]);
         all_match = all_match & same[i];
      end
      if (dets.d0 == '0) begin
         code    = POS_DEGENERATE;
         ref_det = '0;
      end else begin
         code    = all_match ? POS_INSIDE : POS_OUTSIDE;
         ref_det = ref_bits(dets.d0);
      end
      beat_in = RSP_DATA_W'({ref_det, code});
   end

   assign in_ready = !skid_valid_ff;
   assign push     = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (!out_valid_ff || rsp_tready) begin
            out_valid_ff  <= skid_valid_ff || push;
            skid_valid_ff <= 1'b0;
         end else if (push) begin
            // output still held: park the beat
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_tready) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : beat_in;
      end
      if (push && out_valid_ff && !rsp_tready) begin
         skid_data_ff <= beat_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

[rtl/core/point_in_tetrahedron_test_unit.sv]
// ----------------------------------------------------------------------------
// point_in_tetrahedron_test_unit: pipelined point-in-tetrahedron classifier
// Five determinant pipelines feed a classification and output stage.
// ----------------------------------------------------------------------------
// Accepts one beat per clock unless the response stalls, and returns one
// result beat per accepted beat, in order. A beat passes the five register
// stages in each determinant pipeline (edge vectors, minor products,
// minors, cofactor products, final sum) and then the output register.
// The five determinants (reference and query-swapped) run in parallel, so
// unstalled throughput is one item per cycle, set by those lockstep pipelines.
// A stalled response freezes the pipeline after one beat lands in the skid
// slot; req_tready is registered-driven and never depends on rsp_tready in
// the same cycle. A point on a face reports outside; a flat tetrahedron
// reports degenerate with a zero determinant.
// ----------------------------------------------------------------------------
module point_in_tetrahedron_test_unit
   import ptt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [47:0] vertex_a, [95:48] vertex_b, [143:96] vertex_c,
   // [191:144] vertex_d, [239:192] query_point
   input  logic [5*FIELD_W-1:0]  req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [1:0] position_code, [56:2] reference_det, [63:57] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [FIELD_W-1:0] va, vb, vc, vd, vq;
   logic               adv;
   logic [DET_STAGES-1:0] vld_ff, vld_in;
   det_set_type        dets;

   assign va = req_tdata[0*FIELD_W +: FIELD_W];
   assign vb = req_tdata[1*FIELD_W +: FIELD_W];
   assign vc = req_tdata[2*FIELD_W +: FIELD_W];
   assign vd = req_tdata[3*FIELD_W +: FIELD_W];
   assign vq = req_tdata[4*FIELD_W +: FIELD_W];

   assign req_tready = adv;

   // valid bits march alongside the determinant stages
   assign vld_in = {vld_ff[DET_STAGES-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   ptt_det_pipe u_det0 (.clock, .adv, .pnt_p(va), .pnt_q(vb), .pnt_r(vc),
                        .pnt_s(vd), .det(dets.d0));
   ptt_det_pipe u_det1 (.clock, .adv, .pnt_p(vq), .pnt_q(vb), .pnt_r(vc),
                        .pnt_s(vd), .det(dets.d1));
   ptt_det_pipe u_det2 (.clock, .adv, .pnt_p(va), .pnt_q(vq), .pnt_r(vc),
                        .pnt_s(vd), .det(dets.d2));
   ptt_det_pipe u_det3 (.clock, .adv, .pnt_p(va), .pnt_q(vb), .pnt_r(vq),
                        .pnt_s(vd), .det(dets.d3));
   ptt_det_pipe u_det4 (.clock, .adv, .pnt_p(va), .pnt_q(vb), .pnt_r(vc),
                        .pnt_s(vq), .det(dets.d4));

   ptt_out_stage u_out (
      .clock,
      .reset,
      .in_valid   (vld_ff[DET_STAGES-1]),
      .dets,
      .in_ready   (adv),
      .rsp_tvalid,
      .rsp_tready,
      .rsp_tdata
   );

endmodule

[bench/point_in_tetrahedron_checker.sv]
// ----------------------------------------------------------------------------
// point_in_tetrahedron_checker: scoreboard for the point-in-tetrahedron unit
// Watches both stream channels, classifies every accepted request beat with
// exact 64-bit determinants, and compares each response beat in order.
// ----------------------------------------------------------------------------
module point_in_tetrahedron_checker
   import ptt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // [47:0] vertex_a, [95:48] vertex_b, [143:96] vertex_c,
   // [191:144] vertex_d, [239:192] query_point
   input  logic [5*FIELD_W-1:0]  req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [1:0] position_code, [56:2] reference_det, [63:57] zero
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   output int                    mismatches,
   output int                    outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      pos_code_type      code;
      logic [REF_W-1:0]  det;
   } verdict_type;

   verdict_type pending_verdicts[$];
   int          rsp_beats = 0;

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   // Signed coordinate idx of a packed point; bits above the field read zero.
   function automatic longint signed coord_of(input logic [FIELD_W-1:0] f, input int idx);
      logic [3*COORD_W-1:0]      widened;
      logic signed [COORD_W-1:0] c;
      widened = f;
      c = COORD_W'(widened >> (idx * COORD_W));
      return c;
   endfunction

   // det of rows (p,1),(q,1),(r,1),(s,1), i.e. minus the triple product of edges
   function automatic longint signed orientation(input logic [FIELD_W-1:0] p, q, r, s);
      longint signed u[3], v[3], w[3];
      for (int i = 0; i < 3; i++) begin
         u[i] = coord_of(q, i) - coord_of(p, i);
         v[i] = coord_of(r, i) - coord_of(p, i);
         w[i] = coord_of(s, i) - coord_of(p, i);
      end
      return -(u[0] * (v[1] * w[2] - v[2] * w[1])
             - u[1] * (v[0] * w[2] - v[2] * w[0])
             + u[2] * (v[0] * w[1] - v[1] * w[0]));
   endfunction

   function automatic verdict_type classify_point(input logic [5*FIELD_W-1:0] beat);
      logic [FIELD_W-1:0] a, b, c, d, q;
      longint signed      ref_vol;
      longint signed      swapped[4];
      verdict_type        v;
      a = beat[0*FIELD_W +: FIELD_W];
      b = beat[1*FIELD_W +: FIELD_W];
      c = beat[2*FIELD_W +: FIELD_W];
      d = beat[3*FIELD_W +: FIELD_W];
      q = beat[4*FIELD_W +: FIELD_W];
      ref_vol    = orientation(a, b, c, d);
      swapped[0] = orientation(q, b, c, d);
      swapped[1] = orientation(a, q, c, d);
      swapped[2] = orientation(a, b, q, d);
      swapped[3] = orientation(a, b, c, q);
      if (ref_vol == 0) begin
         v.code = POS_DEGENERATE;
         v.det  = '0;
         return v;
      end
      // inside only when every swapped volume has the strict sign of the reference
      v.code = POS_INSIDE;
      for (int i = 0; i < 4; i++)
         if (swapped[i] == 0 || ((swapped[i] > 0) != (ref_vol > 0)))
            v.code = POS_OUTSIDE;
      v.det = ref_vol[REF_W-1:0];
      return v;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("%0t ns: response beat %0d, %s got 0x%0h, want 0x%0h",
               $realtime, rsp_beats, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      verdict_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_verdicts.size() == 0) begin
               report("unexpected beat, code", rsp_tdata[1:0], 0);
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_tdata[1:0] !== want.code)
                  report("position_code", rsp_tdata[1:0], want.code);
               if (rsp_tdata[2 +: REF_W] !== want.det)
                  report("reference_det", rsp_tdata[2 +: REF_W], want.det);
            end
            rsp_beats++;
         end
         if (req_tvalid && req_tready)
            pending_verdicts.push_back(classify_point(req_tdata));
      end
      outstanding <= pending_verdicts.size();
   end

endmodule

[bench/point_in_tetrahedron_test_unit_tb.sv]
// ----------------------------------------------------------------------------
// point_in_tetrahedron_test_unit_tb: top-level bench for the classifier
// Drives directed extremes, degenerate, face and vertex cases, then random
// tetrahedra, half with convex-combination queries, under bursty sending
// and a patterned response stall; the checker scores every response beat.
// ----------------------------------------------------------------------------
module point_in_tetrahedron_test_unit_tb
   import ptt_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEMS        = 1250;
   localparam int MAX_C        = 32767;
   localparam int MIN_C        = -32768;
   localparam int DRAIN_LIMIT  = 20000;
   localparam int SETTLE       = 12;
   localparam int SINK_OPEN    = 0;
   localparam int SINK_CHOPPY  = 1;
   localparam int SINK_CLOGGED = 2;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [5*FIELD_W-1:0]  req_tdata  = '0;
   logic                  rsp_tready = 1'b0;
   logic                  req_tready;
   logic                  rsp_tvalid;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   int                    mismatches;
   int                    outstanding;

   int sink_mode  = SINK_OPEN;
   int sink_run   = 0;
   int burst_left = 0;
   bit held_high  = 1'b0;

   point_in_tetrahedron_test_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   point_in_tetrahedron_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #1 clock = ~clock;

   // Response stall pattern: segments of open, choppy or mostly clogged ready.
   always @(posedge clock) begin
      if (sink_run == 0) begin
         sink_mode <= $urandom_range(2);
         sink_run  <= $urandom_range(200, 20);
      end else begin
         sink_run <= sink_run - 1;
      end
      case (sink_mode)
         SINK_OPEN:   rsp_tready <= 1'b1;
         SINK_CHOPPY: rsp_tready <= 1'($urandom_range(1));
         default:     rsp_tready <= ($urandom_range(4) == 0);
      endcase
   end

   function automatic logic [FIELD_W-1:0] pt(input int x, input int y, input int z);
      return {COORD_W'(z), COORD_W'(y), COORD_W'(x)};
   endfunction

   function automatic logic [5*FIELD_W-1:0] shape(input logic [FIELD_W-1:0] a, b, c, d, q);
      return {q, d, c, b, a};
   endfunction

   // Send one beat, then either keep the burst going or open a gap.
   task automatic offer(input logic [5*FIELD_W-1:0] beat);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      held_high  = 1'b1;
      do @(posedge clock); while (!req_tready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            held_high  = 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(3) == 0) ? $urandom_range(150, 40) : $urandom_range(12);
      end
   endtask

   // Hold off the sender until every outstanding result has come back or DRAIN_LIMIT runs out.
   task automatic drain_results();
      int waited;
      waited = 0;
      if (held_high) begin
         req_tvalid <= 1'b0;
         held_high  = 1'b0;
      end
      do begin
         @(posedge clock);
         waited++;
      end while (outstanding != 0 && waited < DRAIN_LIMIT);
   endtask

   initial begin
      int                   kind;
      int                   v[5][3];
      int                   wt[4];
      int                   wsum;
      logic [255:0]         noise;
      logic [FIELD_W-1:0]   lo, hi;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: degenerate, extremes, both orientations, faces and vertices
      offer('0);
      offer('1);
      lo = pt(MIN_C, MIN_C, MIN_C);
      offer(shape(lo, pt(MAX_C, MIN_C, MIN_C), pt(MIN_C, MAX_C, MIN_C),
                  pt(MIN_C, MIN_C, MAX_C), pt(-30000, -30000, -30000)));
      offer(shape(lo, pt(MIN_C, MAX_C, MIN_C), pt(MAX_C, MIN_C, MIN_C),
                  pt(MIN_C, MIN_C, MAX_C), pt(-30000, -30000, -30000)));
      offer(shape(lo, pt(MAX_C, MIN_C, MIN_C), pt(MIN_C, MAX_C, MIN_C),
                  pt(MIN_C, MIN_C, MAX_C), pt(MAX_C, MAX_C, MAX_C)));
      offer(shape(lo, pt(MAX_C, MIN_C, MIN_C), pt(MIN_C, MAX_C, MIN_C),
                  pt(MIN_C, MIN_C, MAX_C), lo));
      offer(shape(lo, pt(MAX_C, MIN_C, MIN_C), pt(MIN_C, MAX_C, MIN_C),
                  pt(MIN_C, MIN_C, MAX_C), pt(MIN_C, -20000, -20000)));
      offer(shape(lo, pt(MAX_C, MIN_C, MIN_C), pt(MIN_C, MAX_C, MIN_C),
                  pt(MIN_C, MIN_C, MAX_C), pt(0, MIN_C, MIN_C)));
      hi = pt(MAX_C, MAX_C, MAX_C);
      offer(shape(hi, pt(MIN_C, MAX_C, MAX_C), pt(MAX_C, MIN_C, MAX_C),
                  pt(MAX_C, MAX_C, MIN_C), pt(30000, 30000, 30000)));
      offer(shape(hi, pt(MIN_C, MAX_C, MAX_C), pt(MAX_C, MIN_C, MAX_C),
                  pt(MAX_C, MAX_C, MIN_C), lo));
      offer(shape(hi, hi, hi, hi, hi));
      // flat, collinear and repeated-vertex tetrahedra
      offer(shape(pt(5, 9, 0), pt(-7, 3, 0), pt(100, -40, 0), pt(2, 2, 0), pt(1, 1, 1)));
      offer(shape(pt(0, 0, 0), pt(1, 1, 1), pt(2, 2, 2), pt(-5, -5, -5), pt(0, 1, 0)));
      offer(shape(pt(3, 4, 5), pt(3, 4, 5), pt(0, 9, 1), pt(7, -2, 6), pt(3, 4, 5)));
      // unit tetrahedron: vertex, outside; scaled copies with the point inside, mirrored, and on a face
      offer(shape(pt(0, 0, 0), pt(1, 0, 0), pt(0, 1, 0), pt(0, 0, 1), pt(0, 0, 0)));
      offer(shape(pt(0, 0, 0), pt(1, 0, 0), pt(0, 1, 0), pt(0, 0, 1), pt(1, 1, 1)));
      offer(shape(pt(0, 0, 0), pt(4, 0, 0), pt(0, 4, 0), pt(0, 0, 4), pt(1, 1, 1)));
      offer(shape(pt(0, 0, 0), pt(0, 4, 0), pt(4, 0, 0), pt(0, 0, 4), pt(1, 1, 1)));
      offer(shape(pt(0, 0, 0), pt(4, 0, 0), pt(0, 4, 0), pt(0, 0, 4), pt(2, 2, 0)));

      drain_results();

      for (int n = 0; n < ITEMS; n++) begin
         if (n == ITEMS / 2)
            drain_results();
         kind = $urandom_range(9);
         if (kind < 2) begin
            noise = {$urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom(), $urandom()};
            offer(noise[5*FIELD_W-1:0]);
         end else begin
            for (int p = 0; p < 5; p++)
               for (int k = 0; k < 3; k++)
                  v[p][k] = (kind < 4) ? int'($urandom_range(8)) - 4
                                       : int'($urandom_range(65535)) + MIN_C;
            // most queries are rounded convex blends of the vertices, so lie in or near the tetrahedron
            if (kind >= 4 && kind <= 8) begin
               wt[0] = $urandom_range(15, 1);
               for (int p = 1; p < 4; p++)
                  wt[p] = $urandom_range(15);
               wsum = wt[0] + wt[1] + wt[2] + wt[3];
               for (int k = 0; k < 3; k++)
                  v[4][k] = (wt[0] * v[0][k] + wt[1] * v[1][k] + wt[2] * v[2][k]
                             + wt[3] * v[3][k]) / wsum;
            end
            offer(shape(pt(v[0][0], v[0][1], v[0][2]), pt(v[1][0], v[1][1], v[1][2]),
                        pt(v[2][0], v[2][1], v[2][2]), pt(v[3][0], v[3][1], v[3][2]),
                        pt(v[4][0], v[4][1], v[4][2])));
         end
      end

      drain_results();
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
